FILE: rtl/tatemp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatemp_pkg
// Shared constants, controller states and command/status bundles for the
// thermistor averaging temperature converter.
// ----------------------------------------------------------------------------
package tatemp_pkg;

	localparam int AVG_DEPTH_DEF = 5;
	localparam int ADC_BITS_DEF  = 10;

	localparam int SAMPLE_W = 10;
	localparam int BETA_W   = 14;
	localparam int TEMP_W   = 15;
	localparam int SUMO_W   = 13;
	localparam int E_W      = 5;
	localparam int K_W      = 5;
	localparam int DIV_N_W  = 64;
	localparam int DIV_D_W  = 48;

	localparam logic [BETA_W-1:0] BETA_RST = 14'd4275;
	localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
	localparam logic [14:0]       T0_CENTI = 15'd29815;
	localparam logic [21:0]       K_NUM    = 22'd2981500;  // 100 * 29815
	localparam logic [6:0]        K_HUNDRED = 7'd100;
	localparam logic [K_W-1:0]    K_LAST   = 5'd31;
	localparam logic [63:0]       ZERO_C   = 64'd27315;
	localparam logic [63:0]       CK_MIN   = 64'd23315;
	localparam logic [63:0]       CK_MAX   = 64'd42315;
	localparam logic signed [TEMP_W-1:0] T_MIN = -15'sd4000;
	localparam logic signed [TEMP_W-1:0] T_MAX = 15'sd15000;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SUM,
		ST_CHECK,
		ST_LN_INIT,
		ST_ZDIV,
		ST_ZWAIT,
		ST_ZCAP,
		ST_Z2,
		ST_KDIV,
		ST_KWAIT,
		ST_KACC,
		ST_LN_STORE,
		ST_LCALC,
		ST_DEN1,
		ST_DEN2,
		ST_DCHK,
		ST_FDIV,
		ST_FWAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load_sample;
		logic sum_clr;
		logic sum_acc;
		logic ln_init;
		logic ln_sel;
		logic zdiv_start;
		logic z_capture;
		logic z2_calc;
		logic kdiv_start;
		logic k_acc;
		logic ln_store;
		logic l_calc;
		logic den1;
		logic den2;
		logic fdiv_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sum_last;
		logic invalid;
		logic div_busy;
		logic k_last;
		logic den_bad;
	} sts_t;

endpackage

FILE: rtl/tatemp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatemp_div
// Restoring serial divider, one quotient bit per cycle; 32 or 64 steps.
// ----------------------------------------------------------------------------
module tatemp_div
	import tatemp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               long_mode,
	input  logic [DIV_N_W-1:0] dividend,
	input  logic [DIV_D_W-1:0] divisor,
	output logic               busy,
	output logic [DIV_N_W-1:0] quotient
);

	logic               busy_q;
	logic [6:0]         cnt_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dsr_q;
	logic [DIV_N_W-1:0] dq_q;
	logic [DIV_D_W:0]   trial;
	logic [DIV_D_W:0]   diff;
	logic               ge;

	always_comb begin
		trial = {rem_q, dq_q[DIV_N_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= long_mode ? 7'd64 : 7'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// short mode: the upper dividend word seeds the remainder
	always_ff @(posedge clk) begin
		if (start) begin
			dsr_q <= divisor;
			rem_q <= long_mode ? '0 : {16'd0, dividend[63:32]};
			dq_q  <= long_mode ? dividend : {dividend[31:0], 32'd0};
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
			dq_q  <= {dq_q[DIV_N_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = dq_q;

endmodule

FILE: rtl/tatemp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatemp_dp
// Datapath: sample ring, sum, fixed-point log series, beta equation, result.
// ----------------------------------------------------------------------------
module tatemp_dp
	import tatemp_pkg::*;
#(
	parameter int AVG_DEPTH = AVG_DEPTH_DEF,
	parameter int ADC_BITS  = ADC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output sts_t                     sts,
	input  logic [SAMPLE_W-1:0]      adc_sample,
	input  logic                     cfg_wr_en,
	input  logic [BETA_W-1:0]        cfg_wr_data,
	output logic signed [TEMP_W-1:0] temperature_centi,
	output logic                     out_of_range,
	output logic [SUMO_W-1:0]        sample_sum
);

	localparam int FULL_SCALE = AVG_DEPTH * ((2 ** ADC_BITS) - 1);
	localparam int SUM_W      = $clog2(FULL_SCALE + 1);
	localparam int IDX_W      = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(AVG_DEPTH - 1);
	localparam logic [IDX_W-1:0] IDX_AFTER = IDX_W'(1 % AVG_DEPTH);
	localparam logic [SUM_W-1:0] FULL_V    = SUM_W'(FULL_SCALE);

	logic [ADC_BITS-1:0] samp;
	logic [ADC_BITS-1:0] ring_q [AVG_DEPTH];
	logic [IDX_W-1:0]    widx_q;
	logic [IDX_W-1:0]    sidx_q;
	logic                primed_q;
	logic [SUM_W-1:0]    sum_q;
	logic [BETA_W-1:0]   beta_q;

	logic [SUM_W-1:0]    ln_x;
	logic [E_W-1:0]      ln_e;
	logic [32:0]         m_full;
	logic [E_W-1:0]      e_q;
	logic [31:0]         m_q;
	logic [31:0]         z_q;
	logic [31:0]         z2_q;
	logic [31:0]         p_q;
	logic [36:0]         s_q;
	logic [K_W-1:0]      k_q;
	logic [63:0]         zz;
	logic [63:0]         pz;
	logic [39:0]         ln_val;
	logic [39:0]         lna_q;
	logic [39:0]         lnb_q;
	logic signed [39:0]  l_diff;
	logic signed [39:0]  l_adj;
	logic signed [39:0]  l_shr;
	logic signed [31:0]  l24_q;
	logic [20:0]         b100_q;
	logic signed [47:0]  tl_q;
	logic [35:0]         num_q;
	logic signed [47:0]  den_q;

	logic                div_start;
	logic                div_long;
	logic [DIV_N_W-1:0]  div_dividend;
	logic [DIV_D_W-1:0]  div_divisor;
	logic                div_busy;
	logic [DIV_N_W-1:0]  div_q;

	if (ADC_BITS <= SAMPLE_W) begin : g_samp_narrow
		assign samp = adc_sample[ADC_BITS-1:0];
	end else begin : g_samp_wide
		assign samp = {{(ADC_BITS - SAMPLE_W){1'b0}}, adc_sample};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q <= BETA_RST;
		end else if (cfg_wr_en) begin
			beta_q <= cfg_wr_data;
		end
	end

	// first sample after reset fills the whole ring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			widx_q   <= '0;
		end else if (cmd.load_sample) begin
			primed_q <= 1'b1;
			if (!primed_q) begin
				widx_q <= IDX_AFTER;
			end else begin
				widx_q <= (widx_q == IDX_LAST) ? '0 : widx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < AVG_DEPTH; i++) begin
			if (cmd.load_sample && (!primed_q || widx_q == IDX_W'(i))) begin
				ring_q[i] <= samp;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_clr) begin
			sum_q  <= '0;
			sidx_q <= '0;
		end else if (cmd.sum_acc) begin
			sum_q  <= sum_q + SUM_W'(ring_q[sidx_q]);
			sidx_q <= (sidx_q == IDX_LAST) ? '0 : sidx_q + IDX_W'(1);
		end
	end

	// log argument and its leading-one position
	always_comb begin
		ln_x = cmd.ln_sel ? sum_q : FULL_V - sum_q;
		ln_e = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (ln_x[i]) begin
				ln_e = E_W'(i);
			end
		end
		m_full = 33'(ln_x) << (6'd32 - {1'b0, ln_e});
	end

	assign zz     = {32'd0, z_q} * {32'd0, z_q};
	assign pz     = {32'd0, p_q} * {32'd0, z2_q};
	assign ln_val = ({35'd0, e_q} * {8'd0, LN2_Q32}) + {2'b00, s_q, 1'b0};
	assign l_diff = $signed(lna_q) - $signed(lnb_q);
	assign l_adj  = l_diff[39] ? l_diff + 40'sd255 : l_diff;
	assign l_shr  = l_adj >>> 8;

	always_ff @(posedge clk) begin
		if (cmd.ln_init) begin
			e_q <= ln_e;
			m_q <= m_full[31:0];
		end
		if (cmd.z_capture) begin
			z_q <= div_q[31:0];
			p_q <= div_q[31:0];
			s_q <= '0;
			k_q <= K_W'(1);
		end else if (cmd.k_acc) begin
			s_q <= s_q + 37'(div_q[31:0]);
			p_q <= pz[63:32];
			k_q <= k_q + K_W'(2);
		end
		if (cmd.z2_calc) begin
			z2_q <= zz[63:32];
		end
		if (cmd.ln_store) begin
			if (cmd.ln_sel) begin
				lnb_q <= ln_val;
			end else begin
				lna_q <= ln_val;
			end
		end
		if (cmd.l_calc) begin
			l24_q <= l_shr[31:0];
		end
		if (cmd.den1) begin
			b100_q <= beta_q * K_HUNDRED;
			tl_q   <= $signed({1'b0, T0_CENTI}) * l24_q;
			num_q  <= beta_q * K_NUM;
		end
		if (cmd.den2) begin
			den_q <= $signed({3'b000, b100_q, 24'd0}) + tl_q;
		end
	end

	always_comb begin
		div_start    = cmd.zdiv_start | cmd.kdiv_start | cmd.fdiv_start;
		div_long     = cmd.fdiv_start;
		div_dividend = {m_q, 32'd0};
		div_divisor  = {14'd0, 2'b10, m_q};
		if (cmd.kdiv_start) begin
			div_dividend = {32'd0, p_q};
			div_divisor  = DIV_D_W'(k_q);
		end else if (cmd.fdiv_start) begin
			div_dividend = {3'b000, num_q, 25'd0} + {16'd0, den_q};
			div_divisor  = {den_q[46:0], 1'b0};
		end
	end

	tatemp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.long_mode(div_long),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_q)
	);

	always_comb begin
		sts.sum_last = (sidx_q == IDX_LAST);
		sts.invalid  = (sum_q == '0) || (sum_q >= FULL_V) || (beta_q == '0);
		sts.div_busy = div_busy;
		sts.k_last   = (k_q == K_LAST);
		sts.den_bad  = den_q[47] || (den_q == '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			sample_sum <= SUMO_W'(sum_q);
			if (sts.invalid || sts.den_bad) begin
				temperature_centi <= '0;
				out_of_range      <= 1'b1;
			end else if (div_q < CK_MIN) begin
				temperature_centi <= T_MIN;
				out_of_range      <= 1'b1;
			end else if (div_q > CK_MAX) begin
				temperature_centi <= T_MAX;
				out_of_range      <= 1'b1;
			end else begin
				temperature_centi <= TEMP_W'(div_q - ZERO_C);
				out_of_range      <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/tatemp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tatemp_ctrl
// Sequencer: sum, two log evaluations, beta equation divide, result hand-off.
// ----------------------------------------------------------------------------
module tatemp_ctrl
	import tatemp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   second_q;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			second_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CHECK) begin
				second_q <= 1'b0;
			end else if (state_q == ST_LN_STORE) begin
				second_q <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.ln_sel = second_q;
		in_ready   = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_sample = 1'b1;
					cmd.sum_clr     = 1'b1;
					state_d         = ST_SUM;
				end
			end
			ST_SUM: begin
				cmd.sum_acc = 1'b1;
				if (sts.sum_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				state_d = sts.invalid ? ST_OUT : ST_LN_INIT;
			end
			ST_LN_INIT: begin
				cmd.ln_init = 1'b1;
				state_d     = ST_ZDIV;
			end
			ST_ZDIV: begin
				cmd.zdiv_start = 1'b1;
				state_d        = ST_ZWAIT;
			end
			ST_ZWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_ZCAP;
				end
			end
			ST_ZCAP: begin
				cmd.z_capture = 1'b1;
				state_d       = ST_Z2;
			end
			ST_Z2: begin
				cmd.z2_calc = 1'b1;
				state_d     = ST_KDIV;
			end
			ST_KDIV: begin
				cmd.kdiv_start = 1'b1;
				state_d        = ST_KWAIT;
			end
			ST_KWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_KACC;
				end
			end
			ST_KACC: begin
				cmd.k_acc = 1'b1;
				state_d   = sts.k_last ? ST_LN_STORE : ST_KDIV;
			end
			ST_LN_STORE: begin
				cmd.ln_store = 1'b1;
				state_d      = second_q ? ST_LCALC : ST_LN_INIT;
			end
			ST_LCALC: begin
				cmd.l_calc = 1'b1;
				state_d    = ST_DEN1;
			end
			ST_DEN1: begin
				cmd.den1 = 1'b1;
				state_d  = ST_DEN2;
			end
			ST_DEN2: begin
				cmd.den2 = 1'b1;
				state_d  = ST_DCHK;
			end
			ST_DCHK: begin
				state_d = sts.den_bad ? ST_OUT : ST_FDIV;
			end
			ST_FDIV: begin
				cmd.fdiv_start = 1'b1;
				state_d        = ST_FWAIT;
			end
			ST_FWAIT: begin
				if (!sts.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/thermistor_adc_average_to_temp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_adc_average_to_temp
// NTC thermistor temperature from a moving average of converter samples.
// ----------------------------------------------------------------------------
// Each request carries one converter sample. It enters a ring of AVG_DEPTH
// entries (the first sample after reset fills all of them), the ring is summed
// and the beta equation gives the temperature in 0.01 C, clamped to -40..150 C
// with out_of_range set on clamping or on an undefined conversion. One sample
// is processed at a time. For a defined conversion, two fixed-point
// logarithms of 16 series terms each and the final quotient all run through
// one shared radix-2 serial divider (32 steps per log division, 64 for the
// last one). A new sample is taken once the result sits in the output
// register.
// ----------------------------------------------------------------------------
module thermistor_adc_average_to_temp
	import tatemp_pkg::*;
#(
	parameter int AVG_DEPTH = AVG_DEPTH_DEF,
	parameter int ADC_BITS  = ADC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [15:0]       s_axis_tdata,   // [9:0] adc_sample
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // [14:0] temperature_centi, [27:15] sample_sum
	output logic              m_axis_tuser,   // [0] out_of_range
	input  logic              cfg_wr_en,
	input  logic [BETA_W-1:0] cfg_wr_data     // beta_value
);

	cmd_t                     cmd;
	sts_t                     sts;
	logic signed [TEMP_W-1:0] temperature_centi;
	logic                     out_of_range;
	logic [SUMO_W-1:0]        sample_sum;

	tatemp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tatemp_dp #(
		.AVG_DEPTH(AVG_DEPTH),
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.adc_sample       (s_axis_tdata[SAMPLE_W-1:0]),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.temperature_centi(temperature_centi),
		.out_of_range     (out_of_range),
		.sample_sum       (sample_sum)
	);

	assign m_axis_tdata = {4'd0, sample_sum, temperature_centi};
	assign m_axis_tuser = out_of_range;

`ifndef SYNTH
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted again while a sample is in flight");

	a_div_idle_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_busy |-> !s_axis_tready)
		else $error("divider running while the block takes a new sample");

	a_in_range_unflagged: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |->
		$signed(m_axis_tdata[14:0]) >= T_MIN && $signed(m_axis_tdata[14:0]) <= T_MAX)
		else $error("unflagged temperature outside the clamp window");
`endif

endmodule

FILE: sim/thermistor_adc_average_to_temp_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_adc_average_to_temp_tb
// Self-checking bench for the averaging thermistor temperature converter.
// ----------------------------------------------------------------------------
// Converter samples are streamed in bursts while the result side stalls on
// its own pattern. A behavioral predictor keeps its own sample ring and beta
// setting, computes the expected temperature, flag and sum per sample, and
// the monitor checks every result against the oldest expectation. Beta is
// changed between phases while the converter is idle.
// ----------------------------------------------------------------------------
module thermistor_adc_average_to_temp_tb;
	import tatemp_pkg::*;

	localparam int DEPTH     = 5;
	localparam int FULL      = DEPTH * 1023;
	localparam int IDLE_WAIT = 2000;

	typedef struct {
		logic signed [TEMP_W-1:0] temp;
		logic                     flag;
		logic [SUMO_W-1:0]        sum;
	} temp_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [15:0]       s_axis_tdata = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [31:0]       m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_wr_en = 1'b0;
	logic [BETA_W-1:0] cfg_wr_data = '0;

	thermistor_adc_average_to_temp u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [9:0]        ring [DEPTH];
	int                wr_ptr;
	bit                primed;
	logic [BETA_W-1:0] beta;

	logic [9:0]   sample_queue [$];
	temp_result_t temp_expected [$];
	int           errors;
	bit           hold_sender;

	function automatic longint ln_q32(int unsigned x);
		int unsigned  e;
		longint unsigned one, m, z, z2, p, s;
		e   = 0;
		one = 64'd1 << 32;
		s   = 0;
		while (e < 31 && (x >> (e + 1)) != 0)
			e++;
		m  = longint'(x) << (32 - e);
		z  = ((m - one) << 32) / (m + one);
		z2 = (z * z) >> 32;
		p  = z;
		for (int k = 1; k <= 31; k += 2) begin
			s += p / k;
			p = (p * z2) >> 32;
		end
		return longint'(e * LN2_Q32 + 2 * s);
	endfunction

	function automatic temp_result_t predict_temp(logic [9:0] sample);
		temp_result_t r;
		int unsigned  sum;
		longint       l24, b, den, num, ck;
		if (!primed) begin
			for (int i = 0; i < DEPTH; i++)
				ring[i] = sample;
			primed = 1'b1;
			wr_ptr = 1;
		end else begin
			ring[wr_ptr] = sample;
			wr_ptr++;
		end
		if (wr_ptr >= DEPTH)
			wr_ptr = 0;
		sum = 0;
		for (int i = 0; i < DEPTH; i++)
			sum += ring[i];
		r.temp = '0;
		r.flag = 1'b0;
		r.sum  = sum[SUMO_W-1:0];
		if (sum == 0 || sum >= FULL || beta == 0) begin
			r.flag = 1'b1;
		end else begin
			l24 = (ln_q32(FULL - sum) - ln_q32(sum)) / 256;
			b   = longint'(beta);
			den = 100 * b * (64'sd1 << 24) + 64'sd29815 * l24;
			if (den <= 0) begin
				r.flag = 1'b1;
			end else begin
				num = 100 * b * 64'sd29815 * (64'sd1 << 24);
				ck  = (2 * num + den) / (2 * den) - 27315;
				if (ck < -4000) begin
					ck = -4000;
					r.flag = 1'b1;
				end else if (ck > 15000) begin
					ck = 15000;
					r.flag = 1'b1;
				end
				r.temp = ck[TEMP_W-1:0];
			end
		end
		return r;
	endfunction

	// sender: bursts with random gaps
	int burst_left, gap_left;
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			temp_expected.push_back(predict_temp(s_axis_tdata[9:0]));
			void'(sample_queue.pop_front());
		end
		if (s_axis_tvalid && !s_axis_tready) begin
			// hold the request
		end else if (hold_sender || gap_left > 0 || sample_queue.size() == 0) begin
			s_axis_tvalid <= 1'b0;
			if (gap_left > 0)
				gap_left <= gap_left - 1;
		end else begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata  <= {6'd0, sample_queue[0]};
			if (burst_left > 0) begin
				burst_left <= burst_left - 1;
			end else begin
				burst_left <= $urandom_range(0, 6);
				gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			end
		end
	end

	// receiver stall pattern and result check
	int stall_phase;
	always @(posedge clk) begin
		temp_result_t exp_r;
		if (m_axis_tvalid && m_axis_tready) begin
			if (temp_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result data=%h user=%b", $time,
					m_axis_tdata, m_axis_tuser);
			end else begin
				exp_r = temp_expected.pop_front();
				if (m_axis_tdata[14:0] !== exp_r.temp || m_axis_tuser !== exp_r.flag
						|| m_axis_tdata[27:15] !== exp_r.sum) begin
					errors++;
					$display("%0t: mismatch expected temp=%0d flag=%b sum=%0d",
						$time, exp_r.temp, exp_r.flag, exp_r.sum,
						" actual temp=%0d flag=%b sum=%0d",
						$signed(m_axis_tdata[14:0]), m_axis_tuser, m_axis_tdata[27:15]);
				end
			end
		end
		stall_phase <= stall_phase + 1;
		case (stall_phase[7:6])
			2'd0:    m_axis_tready <= 1'b1;
			2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
			2'd2:    m_axis_tready <= stall_phase[2];
			default: m_axis_tready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic wait_drained();
		while (sample_queue.size() != 0 || s_axis_tvalid || temp_expected.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic write_beta(logic [BETA_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		beta = value;
		@(posedge clk);
	endtask

	task automatic add_random(int count);
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       sample_queue.push_back($urandom_range(0, 3) == 0 ? 10'd0 : 10'd1023);
				1:       sample_queue.push_back($urandom_range(0, 1023));
				2, 3:    sample_queue.push_back($urandom_range(0, 40));
				4, 5:    sample_queue.push_back($urandom_range(980, 1023));
				default: sample_queue.push_back($urandom_range(100, 920));
			endcase
		end
	endtask

	initial begin
		logic [BETA_W-1:0] betas [6];
		errors = 0;
		hold_sender = 1'b0;
		wr_ptr = 0;
		primed = 1'b0;
		beta = BETA_RST;
		burst_left = 0;
		gap_left = 0;
		stall_phase = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: all zero sum, full scale, edges, single bits
		foreach (betas[i]) betas[i] = 0;
		sample_queue.push_back(10'd0);
		sample_queue.push_back(10'd1);
		for (int i = 0; i < 5; i++) sample_queue.push_back(10'd1023);
		for (int i = 0; i < 10; i++) sample_queue.push_back(10'd1 << i);
		sample_queue.push_back(10'd512);
		sample_queue.push_back(10'd0);
		sample_queue.push_back(10'd1022);
		sample_queue.push_back(10'd3);
		wait_drained();

		betas[0] = 14'd1000;
		betas[1] = 14'd10000;
		betas[2] = 14'd0;
		betas[3] = 14'h3FFF;
		betas[4] = 14'd1;
		betas[5] = 14'd3950;
		for (int ph = 0; ph < 6; ph++) begin
			write_beta(betas[ph]);
			add_random(ph == 5 ? 700 : 140);
			if (ph == 3) begin
				// pause the sender until every result is back
				while (sample_queue.size() > 70) @(posedge clk);
				hold_sender = 1'b1;
				while (temp_expected.size() != 0 || s_axis_tvalid) @(posedge clk);
				hold_sender = 1'b0;
			end
			wait_drained();
		end
		write_beta($urandom_range(1000, 10000));
		add_random(60);
		wait_drained();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#100ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
